// File: rtl/core/spmx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmx_pkg
// Shared widths, constants and command / register codes of the splitmix64
// distribution draw block.
// ----------------------------------------------------------------------------
package spmx_pkg;

    localparam int WORD_W     = 64;
    localparam int CNT_W      = 6;    // bit counter over one 64-bit word
    localparam int VAL_W      = 32;
    localparam int DIV_W      = VAL_W + 1;  // range span reaches 2^32
    localparam int PROB_W     = 54;
    localparam int CMD_W      = 2;
    localparam int CNTL_W     = 3;    // list_count register width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 104;

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;
    localparam int MIX_SHIFT_C = 31;

    localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHANCE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RAW     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_COUNT = 3'd3;
    localparam int                   REG_LIST_BASE  = 4;

    // handshake between the sequencer and a serial unit
    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/splitmix64_distribution_draw.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// splitmix64_distribution_draw
// Splitmix64 generator serving restart, raw word, distribution draw and
// chance test commands, built on bit-serial multiply and remainder units.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                  | tuser
//  s_      | in  | probability[53:0], 2 pad bits       | command[1:0]
//  m_      | out | raw_word, drawn_value, hit, 7 pad   | -
//  cfg_    | in  | cfg_wdata, index from cfg_index     | -
//
//  Work per command, accept to next accept:
//  Restart, one-value or reversed range, zero / saturated chance: no multiply.
//  Raw word and chance test: two serial multiplies.
//  Draw: the two serial multiplies, then the serial remainder unit.
//  One word in flight; s_tready is high only while the sequencer is idle.
//  A finished word waits in the output register while the next one is taken.
//  Reset is synchronous, active low; control, counter and config clear to zero.
// ----------------------------------------------------------------------------
module splitmix64_distribution_draw #(
    parameter int LIST_DEPTH     = 4,
    parameter int FRACTION_WIDTH = 53
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [spmx_pkg::S_TDATA_W-1:0]  s_tdata,   // probability
    input  wire logic [spmx_pkg::CMD_W-1:0]      s_tuser,   // command
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [spmx_pkg::M_TDATA_W-1:0]       m_tdata,   // raw_word, drawn_value, hit
    input  wire logic                            cfg_wr_en,
    input  wire logic [spmx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spmx_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int W       = spmx_pkg::WORD_W;
    localparam int VW      = spmx_pkg::VAL_W;
    localparam int FR_SHFT = W - FRACTION_WIDTH;
    localparam logic [W:0] PROB_ONE = (W+1)'(1) << FRACTION_WIDTH;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_A_GO = 4'd1;
    localparam logic [3:0] ST_MUL_A    = 4'd2;
    localparam logic [3:0] ST_MUL_B_GO = 4'd3;
    localparam logic [3:0] ST_MUL_B    = 4'd4;
    localparam logic [3:0] ST_POST     = 4'd5;
    localparam logic [3:0] ST_MOD      = 4'd6;
    localparam logic [3:0] ST_DONE     = 4'd7;

    // configuration
    logic [W-1:0]                    seed_reg;
    logic signed [VW-1:0]            range_low_reg;
    logic signed [VW-1:0]            range_high_reg;
    logic [spmx_pkg::CNTL_W-1:0]     list_count_reg;
    logic signed [VW-1:0]            list_reg [LIST_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg       <= '0;
            range_low_reg  <= '0;
            range_high_reg <= '0;
            list_count_reg <= '0;
            for (int i = 0; i < LIST_DEPTH; i++) begin
                list_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == spmx_pkg::REG_SEED) begin
                seed_reg <= cfg_wdata;
            end
            if (cfg_index == spmx_pkg::REG_RANGE_LOW) begin
                range_low_reg <= cfg_wdata[VW-1:0];
            end
            if (cfg_index == spmx_pkg::REG_RANGE_HIGH) begin
                range_high_reg <= cfg_wdata[VW-1:0];
            end
            if (cfg_index == spmx_pkg::REG_LIST_COUNT) begin
                list_count_reg <= cfg_wdata[spmx_pkg::CNTL_W-1:0];
            end
            for (int i = 0; i < LIST_DEPTH; i++) begin
                if (cfg_index == spmx_pkg::CFG_IDX_W'(spmx_pkg::REG_LIST_BASE + i)) begin
                    list_reg[i] <= cfg_wdata[VW-1:0];
                end
            end
        end
    end

    // sequencer state
    logic [3:0]                  state_reg, state_next;
    logic [W-1:0]                ctr_reg, ctr_next;
    logic [W-1:0]                word_reg, word_next;
    logic [spmx_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [spmx_pkg::PROB_W-1:0] prob_reg, prob_next;
    logic [W-1:0]                res_raw_reg, res_raw_next;
    logic [VW-1:0]               res_drawn_reg, res_drawn_next;
    logic                        res_hit_reg, res_hit_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [spmx_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    spmx_pkg::unit_ctl_t         mul_ctl, mod_ctl;
    spmx_pkg::unit_sts_t         mul_sts, mod_sts;
    logic [W-1:0]                mul_a, mul_b, mul_p;
    logic [spmx_pkg::DIV_W-1:0]  mod_div, mod_rem;

    logic [spmx_pkg::CNTL_W-1:0] count_eff;
    logic                        list_mode;
    logic [spmx_pkg::DIV_W-1:0]  span;
    logic [spmx_pkg::PROB_W-1:0] prob_in;
    logic [VW-1:0]               list_pick;
    logic [W-1:0]                post_word;

    assign count_eff = (list_count_reg > spmx_pkg::CNTL_W'(LIST_DEPTH))
                     ? spmx_pkg::CNTL_W'(LIST_DEPTH) : list_count_reg;
    assign list_mode = (count_eff != '0);
    assign span      = spmx_pkg::DIV_W'({range_high_reg[VW-1], range_high_reg}
                     - {range_low_reg[VW-1], range_low_reg} + 1'b1);
    assign prob_in   = s_tdata[spmx_pkg::PROB_W-1:0];
    assign mod_div   = list_mode ? spmx_pkg::DIV_W'(count_eff) : span;
    assign post_word = mul_p ^ (mul_p >> spmx_pkg::MIX_SHIFT_C);

    always_comb begin
        list_pick = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (mod_rem == spmx_pkg::DIV_W'(i)) begin
                list_pick = list_reg[i];
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        word_next      = word_reg;
        cmd_next       = cmd_reg;
        prob_next      = prob_reg;
        res_raw_next   = res_raw_reg;
        res_drawn_next = res_drawn_reg;
        res_hit_next   = res_hit_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        mul_ctl.start  = 1'b0;
        mod_ctl.start  = 1'b0;
        mul_a          = ctr_reg ^ (ctr_reg >> spmx_pkg::MIX_SHIFT_A);
        mul_b          = spmx_pkg::MIX_MUL_A;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next       = s_tuser;
                    prob_next      = prob_in;
                    res_raw_next   = '0;
                    res_drawn_next = '0;
                    res_hit_next   = 1'b0;
                    state_next     = ST_MUL_A_GO;
                    case (s_tuser)
                        spmx_pkg::CMD_RESTART: begin
                            ctr_next   = seed_reg;
                            state_next = ST_DONE;
                        end
                        spmx_pkg::CMD_DRAW: begin
                            // one-value or reversed range: no word taken
                            if (!list_mode && !(range_high_reg > range_low_reg)) begin
                                res_drawn_next = range_low_reg;
                                state_next     = ST_DONE;
                            end
                        end
                        spmx_pkg::CMD_CHANCE: begin
                            if (prob_in == '0) begin
                                state_next = ST_DONE;
                            end else if ((W+1)'(prob_in) >= PROB_ONE) begin
                                res_hit_next = 1'b1;
                                state_next   = ST_DONE;
                            end
                        end
                        default: ;
                    endcase
                    if (state_next == ST_MUL_A_GO) begin
                        ctr_next = ctr_reg + spmx_pkg::GOLDEN_STEP;
                    end
                end
            end
            ST_MUL_A_GO: begin
                mul_ctl.start = 1'b1;
                state_next    = ST_MUL_A;
            end
            ST_MUL_A: begin
                if (mul_sts.done) begin
                    state_next = ST_MUL_B_GO;
                end
            end
            ST_MUL_B_GO: begin
                mul_ctl.start = 1'b1;
                mul_a         = mul_p ^ (mul_p >> spmx_pkg::MIX_SHIFT_B);
                mul_b         = spmx_pkg::MIX_MUL_B;
                state_next    = ST_MUL_B;
            end
            ST_MUL_B: begin
                if (mul_sts.done) begin
                    word_next  = post_word;
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                case (cmd_reg)
                    spmx_pkg::CMD_RAW: begin
                        res_raw_next = word_reg;
                        state_next   = ST_DONE;
                    end
                    spmx_pkg::CMD_CHANCE: begin
                        res_hit_next = ((word_reg >> FR_SHFT) < W'(prob_reg));
                        state_next   = ST_DONE;
                    end
                    default: begin
                        mod_ctl.start = 1'b1;
                        state_next    = ST_MOD;
                    end
                endcase
            end
            ST_MOD: begin
                if (mod_sts.done) begin
                    if (list_mode) begin
                        res_drawn_next = list_pick;
                    end else begin
                        res_drawn_next = range_low_reg + mod_rem[VW-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = spmx_pkg::M_TDATA_W'({res_hit_reg, res_drawn_reg,
                                                          res_raw_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ctr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ctr_reg      <= ctr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        word_reg      <= word_next;
        cmd_reg       <= cmd_next;
        prob_reg      <= prob_next;
        res_raw_reg   <= res_raw_next;
        res_drawn_reg <= res_drawn_next;
        res_hit_reg   <= res_hit_next;
        m_tdata_reg   <= m_tdata_next;
    end

    spmx_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .sts     (mul_sts),
        .product (mul_p)
    );

    spmx_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mod_ctl),
        .dividend  (word_reg),
        .divisor   (mod_div),
        .sts       (mod_sts),
        .remainder (mod_rem)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // multiplier finishes only while the sequencer waits on it
    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_sts.done |-> (state_reg == ST_MUL_A || state_reg == ST_MUL_B))
        else $error("multiplier done outside a multiply wait");

    a_mod_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_sts.done |-> (state_reg == ST_MOD && !mul_sts.busy))
        else $error("remainder done outside its wait");

    a_restart_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == spmx_pkg::CMD_RESTART)
        |=> (ctr_reg == $past(seed_reg)))
        else $error("restart did not load the seed");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_DONE))
        else $error("output word raised outside the done state");

endmodule

`default_nettype wire

// File: rtl/core/spmx_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmx_mul
// Bit-serial 64x64 multiplier, low 64 bits of the product; one multiplier
// bit per cycle, done pulses in the cycle after the last bit.
// ----------------------------------------------------------------------------
module spmx_mul (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire spmx_pkg::unit_ctl_t         ctl,
    input  wire logic [spmx_pkg::WORD_W-1:0] op_a,
    input  wire logic [spmx_pkg::WORD_W-1:0] op_b,
    output spmx_pkg::unit_sts_t              sts,
    output logic [spmx_pkg::WORD_W-1:0]      product
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [spmx_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [spmx_pkg::WORD_W-1:0] a_reg, a_next;
    logic [spmx_pkg::WORD_W-1:0] b_reg, b_next;
    logic [spmx_pkg::WORD_W-1:0] acc_reg, acc_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = acc_reg;

endmodule

`default_nettype wire

// File: rtl/core/spmx_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmx_mod
// Bit-serial restoring remainder of a 64-bit word by a divisor of up to
// 33 bits; one dividend bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module spmx_mod (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire spmx_pkg::unit_ctl_t         ctl,
    input  wire logic [spmx_pkg::WORD_W-1:0] dividend,
    input  wire logic [spmx_pkg::DIV_W-1:0]  divisor,
    output spmx_pkg::unit_sts_t              sts,
    output logic [spmx_pkg::DIV_W-1:0]       remainder
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [spmx_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [spmx_pkg::WORD_W-1:0] dvd_reg, dvd_next;
    logic [spmx_pkg::DIV_W-1:0]  div_reg, div_next;
    logic [spmx_pkg::DIV_W-1:0]  rem_reg, rem_next;
    logic [spmx_pkg::DIV_W:0]    trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[spmx_pkg::WORD_W-1]};
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // partial remainder stays below the divisor, so one subtract
            if (trial >= {1'b0, div_reg}) begin
                rem_next = spmx_pkg::DIV_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[spmx_pkg::DIV_W-1:0];
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: bench/splitmix64_distribution_draw_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splitmix64_distribution_draw_test
// Self-checking bench for the splitmix64 draw block. A scoreboard class keeps
// its own generator and register copy, works out each word's expected result
// when a command is taken, and compares the block's results in order. A short
// directed run covers the corner cases, then randomized phases reload every
// register and send mixed commands, all but one under random stalls on both channels.
// ----------------------------------------------------------------------------
module splitmix64_distribution_draw_test;

    localparam int PROB_FRAC_W = 53;
    localparam int LIST_SLOTS  = 4;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 194;

    typedef struct {
        logic [63:0] raw_word;
        logic [31:0] drawn_value;
        logic        hit;
    } draw_result_t;

    class splitmix_scoreboard;
        logic [63:0]        counter;
        logic [63:0]        seed;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [2:0]         list_count;
        logic [31:0]        list_vals [LIST_SLOTS];
        draw_result_t       expected_words [$];
        int                 mismatches;

        function new();
            counter    = '0;
            seed       = '0;
            range_low  = '0;
            range_high = '0;
            list_count = '0;
            foreach (list_vals[i]) list_vals[i] = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [spmx_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                spmx_pkg::REG_SEED:       seed = val;
                spmx_pkg::REG_RANGE_LOW:  range_low = val[31:0];
                spmx_pkg::REG_RANGE_HIGH: range_high = val[31:0];
                spmx_pkg::REG_LIST_COUNT: list_count = val[2:0];
                default: list_vals[idx - spmx_pkg::REG_LIST_BASE] = val[31:0];
            endcase
        endfunction

        function logic [63:0] mix_next();
            logic [63:0] z;
            counter = counter + spmx_pkg::GOLDEN_STEP;
            z = counter;
            z = (z ^ (z >> spmx_pkg::MIX_SHIFT_A)) * spmx_pkg::MIX_MUL_A;
            z = (z ^ (z >> spmx_pkg::MIX_SHIFT_B)) * spmx_pkg::MIX_MUL_B;
            return z ^ (z >> spmx_pkg::MIX_SHIFT_C);
        endfunction

        function logic [31:0] draw_value();
            int          n;
            longint      lo;
            longint      hi;
            logic [63:0] span;
            logic [63:0] w;
            n = (list_count > LIST_SLOTS) ? LIST_SLOTS : int'(list_count);
            if (n != 0) begin
                w = mix_next();
                return list_vals[int'(w % 64'(n))];
            end
            lo = longint'(range_low);
            hi = longint'(range_high);
            // one-value or reversed range: no word is taken
            if (hi <= lo) return range_low;
            span = 64'(hi - lo) + 64'd1;
            w = mix_next();
            return 32'(lo + longint'(w % span));
        endfunction

        function logic chance_hit(logic [spmx_pkg::PROB_W-1:0] prob);
            logic [63:0] w;
            if (prob == '0) return 1'b0;
            if (prob >= (54'd1 << PROB_FRAC_W)) return 1'b1;
            w = mix_next();
            return (w >> (64 - PROB_FRAC_W)) < 64'(prob);
        endfunction

        function void note_command(logic [spmx_pkg::CMD_W-1:0] cmd,
                                   logic [spmx_pkg::PROB_W-1:0] prob);
            draw_result_t r;
            r.raw_word    = '0;
            r.drawn_value = '0;
            r.hit         = 1'b0;
            case (cmd)
                spmx_pkg::CMD_DRAW:   r.drawn_value = draw_value();
                spmx_pkg::CMD_CHANCE: r.hit = chance_hit(prob);
                spmx_pkg::CMD_RAW:    r.raw_word = mix_next();
                default:              counter = seed;
            endcase
            expected_words.push_back(r);
        endfunction

        function void check_word(logic [spmx_pkg::M_TDATA_W-1:0] data);
            draw_result_t e;
            if (expected_words.size() == 0) begin
                $error("result word with no pending command: %h", data);
                mismatches++;
                return;
            end
            e = expected_words.pop_front();
            if (data[63:0] !== e.raw_word) begin
                $error("raw_word: expected %h, got %h", e.raw_word, data[63:0]);
                mismatches++;
            end
            if (data[95:64] !== e.drawn_value) begin
                $error("drawn_value: expected %0d, got %0d",
                       $signed(e.drawn_value), $signed(data[95:64]));
                mismatches++;
            end
            if (data[96] !== e.hit) begin
                $error("hit: expected %b, got %b", e.hit, data[96]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [spmx_pkg::S_TDATA_W-1:0]   s_tdata   = '0;   // probability[53:0], 2 pad bits
    logic [spmx_pkg::CMD_W-1:0]       s_tuser   = '0;   // command[1:0]
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [spmx_pkg::M_TDATA_W-1:0]   m_tdata;          // raw_word, drawn_value, hit, 7 pad
    logic                             cfg_wr_en = 1'b0;
    logic [spmx_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [spmx_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                             quiet     = 1'b0; // no idling on either side

    splitmix_scoreboard sb = new();

    splitmix64_distribution_draw #(
        .LIST_DEPTH     (LIST_SLOTS),
        .FRACTION_WIDTH (PROB_FRAC_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #30ms;
        $display("splitmix64_distribution_draw regression: fail");
        $finish;
    end

    // result side: random stalls unless quiet, checked on every accepted word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
        m_tready <= quiet || ($urandom_range(0, 99) >= 26);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [spmx_pkg::PROB_W-1:0] pick_probability();
        logic [31:0] hi_bits;
        logic [31:0] lo_bits;
        hi_bits = $urandom;
        lo_bits = $urandom;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 54'd1 << PROB_FRAC_W;
            2:       return {1'b1, hi_bits[20:0], lo_bits};   // saturated
            3:       return 54'($urandom_range(1, 16));
            4:       return (54'd1 << PROB_FRAC_W) - 54'($urandom_range(1, 16));
            default: return {1'b0, hi_bits[20:0], lo_bits};
        endcase
    endfunction

    function automatic logic [spmx_pkg::CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return spmx_pkg::CMD_DRAW;
        if (r < 65) return spmx_pkg::CMD_CHANCE;
        if (r < 90) return spmx_pkg::CMD_RAW;
        return spmx_pkg::CMD_RESTART;
    endfunction

    task automatic send_word(logic [spmx_pkg::CMD_W-1:0] cmd,
                             logic [spmx_pkg::PROB_W-1:0] prob);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 26) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 220)
                                              : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, prob};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, prob);
    endtask

    // registers change only once every pending word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [spmx_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic write_list(logic [31:0] v0, logic [31:0] v1,
                              logic [31:0] v2, logic [31:0] v3);
        write_reg(spmx_pkg::CFG_IDX_W'(spmx_pkg::REG_LIST_BASE + 0), {$urandom, v0});
        write_reg(spmx_pkg::CFG_IDX_W'(spmx_pkg::REG_LIST_BASE + 1), {$urandom, v1});
        write_reg(spmx_pkg::CFG_IDX_W'(spmx_pkg::REG_LIST_BASE + 2), {$urandom, v2});
        write_reg(spmx_pkg::CFG_IDX_W'(spmx_pkg::REG_LIST_BASE + 3), {$urandom, v3});
    endtask

    task automatic shuffle_config();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] s;
        lo = $urandom;
        case ($urandom_range(0, 4))
            0: begin
                lo = 32'h8000_0000;
                hi = 32'h7fff_ffff;
            end
            1: hi = lo + 32'($urandom_range(1, 20));
            2: hi = lo - 32'($urandom_range(0, 5));   // one value or reversed
            3: hi = $urandom;
            default: begin
                lo = -32'($urandom_range(0, 1000));
                hi = 32'($urandom_range(0, 1000));
            end
        endcase
        case ($urandom_range(0, 3))
            0:       s = '0;
            1:       s = '1;
            default: s = rand64();
        endcase
        write_reg(spmx_pkg::REG_SEED, s);
        write_reg(spmx_pkg::REG_RANGE_LOW, {$urandom, lo});
        write_reg(spmx_pkg::REG_RANGE_HIGH, {$urandom, hi});
        write_reg(spmx_pkg::REG_LIST_COUNT,
                  {61'($urandom), ($urandom_range(0, 1) != 0) ? 3'd0
                                                              : 3'($urandom_range(1, 7))});
        write_list($urandom, $urandom, $urandom, $urandom);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: range 0..0 holds one value, so draws give 0 without a step
        send_word(spmx_pkg::CMD_RAW, pick_probability());
        send_word(spmx_pkg::CMD_DRAW, pick_probability());
        send_word(spmx_pkg::CMD_CHANCE, '0);
        send_word(spmx_pkg::CMD_CHANCE, 54'd1 << PROB_FRAC_W);
        send_word(spmx_pkg::CMD_CHANCE, '1);
        send_word(spmx_pkg::CMD_CHANCE, 54'd1);
        send_word(spmx_pkg::CMD_CHANCE, (54'd1 << PROB_FRAC_W) - 54'd1);
        send_word(spmx_pkg::CMD_RESTART, '1);
        send_word(spmx_pkg::CMD_RAW, '0);
        drain();

        // widest range and all-ones seed
        write_reg(spmx_pkg::REG_SEED, '1);
        write_reg(spmx_pkg::REG_RANGE_LOW, 64'h0000_0000_8000_0000);
        write_reg(spmx_pkg::REG_RANGE_HIGH, 64'hffff_ffff_7fff_ffff);
        // low bits zero: range mode
        write_reg(spmx_pkg::REG_LIST_COUNT, 64'hffff_ffff_ffff_fff8);
        write_list(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
        cfg_wr_en <= 1'b0;
        send_word(spmx_pkg::CMD_RESTART, '0);
        send_word(spmx_pkg::CMD_DRAW, '0);
        send_word(spmx_pkg::CMD_DRAW, '1);
        send_word(spmx_pkg::CMD_RAW, '0);
        send_word(spmx_pkg::CMD_CHANCE, 54'd1 << (PROB_FRAC_W - 1));
        drain();

        // list count past the list depth clamps to four entries
        write_reg(spmx_pkg::REG_LIST_COUNT, 64'd7);
        cfg_wr_en <= 1'b0;
        send_word(spmx_pkg::CMD_DRAW, '0);
        send_word(spmx_pkg::CMD_DRAW, '0);
        send_word(spmx_pkg::CMD_DRAW, '0);
        drain();

        // reversed range, then a range of one value at the top
        write_reg(spmx_pkg::REG_LIST_COUNT, 64'd0);
        write_reg(spmx_pkg::REG_RANGE_LOW, 64'd5);
        write_reg(spmx_pkg::REG_RANGE_HIGH, 64'hffff_ffff_ffff_fffb);
        cfg_wr_en <= 1'b0;
        send_word(spmx_pkg::CMD_DRAW, '0);
        send_word(spmx_pkg::CMD_RAW, '0);
        drain();
        write_reg(spmx_pkg::REG_RANGE_LOW, 64'h7fff_ffff);
        write_reg(spmx_pkg::REG_RANGE_HIGH, 64'h7fff_ffff);
        cfg_wr_en <= 1'b0;
        send_word(spmx_pkg::CMD_DRAW, '0);
        send_word(spmx_pkg::CMD_RAW, '0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            quiet <= (p == 2);
            shuffle_config();
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(pick_command(), pick_probability());
            drain();
        end

        repeat (300) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("splitmix64_distribution_draw regression: pass");
        else
            $display("splitmix64_distribution_draw regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/spmx_pkg.sv
rtl/core/spmx_mul.sv
rtl/core/spmx_mod.sv
rtl/core/splitmix64_distribution_draw.sv
bench/splitmix64_distribution_draw_test.sv
